### hdl/aavr_pkg.sv
// Package for the axis-angle vector rotation block: widths, constants,
// the CORDIC arctangent table and the rounding multiply used by the matrix and axis products.
// No dependencies.
package aavr_pkg;

    localparam int CORDIC_ITERATIONS = 24;

    // Internal widths.
    localparam int XY_W = 34;   // CORDIC x and y
    localparam int Z_W  = 33;   // CORDIC angle accumulator, Q2.30 radians
    localparam int MW   = 36;   // cos, sin, 1-cos and first-level products
    localparam int GW   = 34;   // axis outer products
    localparam int EW   = 37;   // rotation matrix entries
    localparam int QW   = 40;   // matrix entry times point component
    localparam int SW   = 42;   // row sum before clipping

    // Angle constants in Q16.16 degrees, held in 27 bits.
    localparam logic signed [26:0] HALF_DEG    = 27'sd11796480;
    localparam logic signed [26:0] FULL_DEG    = 27'sd23592960;
    localparam logic signed [26:0] QUARTER_DEG = 27'sd5898240;

    localparam logic [26:0]           DEG2RAD_Q32 = 27'd74961321;
    localparam logic signed [XY_W-1:0] GAIN_INV   = XY_W'(652032874);
    localparam logic signed [MW-1:0]   ONE_Q30    = MW'(64'd1 << 30);

    localparam logic signed [31:0] AXIS_X_RST = 32'sd0;
    localparam logic signed [31:0] AXIS_Y_RST = 32'sd0;
    localparam logic signed [31:0] AXIS_Z_RST = 32'sd1073741824;

    // Configuration register indexes.
    localparam logic [1:0] REG_AXIS_X = 2'd0;
    localparam logic [1:0] REG_AXIS_Y = 2'd1;
    localparam logic [1:0] REG_AXIS_Z = 2'd2;

    // Two angle stages, the CORDIC stages and five matrix stages.
    localparam int PIPE_LATENCY = CORDIC_ITERATIONS + 7;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef struct packed {
        logic               cneg;
        logic               sneg;
        logic signed [Z_W-1:0] z;
        t_point             pt;
    } t_angle;

    typedef struct packed {
        logic                   cneg;
        logic                   sneg;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        t_point                 pt;
    } t_trig;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Signed product scaled by 2^-30, rounded to nearest with ties away from zero.
    function automatic logic signed [47:0] mul_rnd30(input logic signed [39:0] a,
                                                     input logic signed [39:0] b);
        logic signed [79:0] p;
        logic [79:0]        mag;
        logic [79:0]        r;
        p   = a * b;
        mag = p[79] ? 80'(-p) : 80'(p);
        r   = (mag + (80'd1 << 29)) >> 30;
        return p[79] ? -48'(r) : 48'(r);
    endfunction

endpackage

### hdl/aavr_angle.sv
// Angle front end: range reduction and folding in degrees, then the
// conversion to Q2.30 radians. Two register stages. Uses aavr_pkg.
module aavr_angle (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [25:0]   i_angle_deg,
    input  aavr_pkg::t_point     i_pt,
    output logic                 o_valid,
    output aavr_pkg::t_angle     o_ang
);

    logic signed [26:0] w_a;
    logic signed [26:0] w_f;
    logic               w_cneg;
    logic [22:0]        n_mag;

    logic               r_v1;
    logic [22:0]        r_mag;
    logic               r_cneg1;
    logic               r_sneg1;
    aavr_pkg::t_point   r_pt1;

    logic [49:0]        w_prod;
    logic               r_v2;
    aavr_pkg::t_angle   r_ang;

    always_comb begin
        w_a = 27'(i_angle_deg);
        // The field spans about +-512 degrees, so one correction is enough.
        if (w_a >= aavr_pkg::HALF_DEG) begin
            w_a = w_a - aavr_pkg::FULL_DEG;
        end else if (w_a < -aavr_pkg::HALF_DEG) begin
            w_a = w_a + aavr_pkg::FULL_DEG;
        end
        w_cneg = 1'b0;
        w_f    = w_a;
        if (w_a > aavr_pkg::QUARTER_DEG) begin
            w_f    = aavr_pkg::HALF_DEG - w_a;
            w_cneg = 1'b1;
        end else if (w_a < -aavr_pkg::QUARTER_DEG) begin
            w_f    = -aavr_pkg::HALF_DEG - w_a;
            w_cneg = 1'b1;
        end
        n_mag = w_f[26] ? 23'(-w_f) : 23'(w_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_mag   <= n_mag;
        r_cneg1 <= w_cneg;
        r_sneg1 <= w_f[26];
        r_pt1   <= i_pt;
        r_ang.z    <= aavr_pkg::Z_W'(w_prod >> 18);
        r_ang.cneg <= r_cneg1;
        r_ang.sneg <= r_sneg1;
        r_ang.pt   <= r_pt1;
    end

    assign w_prod  = 50'(r_mag) * 50'(aavr_pkg::DEG2RAD_Q32) + (50'd1 << 17);
    assign o_valid = r_v2;
    assign o_ang   = r_ang;

endmodule

### hdl/aavr_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, carrying the
// point and sign flags alongside. Uses aavr_pkg.
module aavr_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  aavr_pkg::t_angle   i_ang,
    output logic               o_valid,
    output aavr_pkg::t_trig    o_trig
);

    localparam int N = aavr_pkg::CORDIC_ITERATIONS;

    logic signed [aavr_pkg::XY_W-1:0] s_x [0:N-1];
    logic signed [aavr_pkg::XY_W-1:0] s_y [0:N-1];
    logic signed [aavr_pkg::Z_W-1:0]  s_z [0:N-1];
    logic                             s_v [0:N-1];
    aavr_pkg::t_point                 s_p [0:N-1];
    logic                             s_c [0:N-1];
    logic                             s_s [0:N-1];

    logic signed [aavr_pkg::XY_W-1:0] r_x [1:N];
    logic signed [aavr_pkg::XY_W-1:0] r_y [1:N];
    logic signed [aavr_pkg::Z_W-1:0]  r_z [1:N];
    logic                             r_v [1:N];
    aavr_pkg::t_point                 r_p [1:N];
    logic                             r_c [1:N];
    logic                             r_s [1:N];

    always_comb begin
        s_x[0] = aavr_pkg::GAIN_INV;
        s_y[0] = '0;
        s_z[0] = i_ang.z;
        s_v[0] = i_valid;
        s_p[0] = i_ang.pt;
        s_c[0] = i_ang.cneg;
        s_s[0] = i_ang.sneg;
        for (int i = 1; i < N; i++) begin
            s_x[i] = r_x[i];
            s_y[i] = r_y[i];
            s_z[i] = r_z[i];
            s_v[i] = r_v[i];
            s_p[i] = r_p[i];
            s_c[i] = r_c[i];
            s_s[i] = r_s[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= s_v[i];
            end
            r_p[i+1] <= s_p[i];
            r_c[i+1] <= s_c[i];
            r_s[i+1] <= s_s[i];
            if (!s_z[i][aavr_pkg::Z_W-1]) begin
                r_x[i+1] <= s_x[i] - (s_y[i] >>> i);
                r_y[i+1] <= s_y[i] + (s_x[i] >>> i);
                r_z[i+1] <= s_z[i] - aavr_pkg::Z_W'(aavr_pkg::atan_q30(5'(i)));
            end else begin
                r_x[i+1] <= s_x[i] + (s_y[i] >>> i);
                r_y[i+1] <= s_y[i] - (s_x[i] >>> i);
                r_z[i+1] <= s_z[i] + aavr_pkg::Z_W'(aavr_pkg::atan_q30(5'(i)));
            end
        end
    end

    assign o_valid     = r_v[N];
    assign o_trig.x    = r_x[N];
    assign o_trig.y    = r_y[N];
    assign o_trig.pt   = r_p[N];
    assign o_trig.cneg = r_c[N];
    assign o_trig.sneg = r_s[N];

endmodule

### hdl/aavr_matrix.sv
// Rotation matrix build and matrix-vector product: sign fix, scaled axis
// products, matrix entries, point products, row sums with clipping.
// Five register stages. Uses aavr_pkg.
module aavr_matrix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  aavr_pkg::t_trig                   i_trig,
    input  logic signed [31:0]                i_axis [0:2],
    input  logic signed [aavr_pkg::GW-1:0]    i_gram [0:5],
    output logic                              o_valid,
    output logic signed [31:0]                o_rot [0:2],
    output logic                              o_saturated
);

    localparam int MW = aavr_pkg::MW;

    // Order of i_gram: xx, yy, zz, xy, yz, zx.
    logic [4:0]              r_v;
    logic signed [MW-1:0]    r_c0, r_sn0, r_t0;
    aavr_pkg::t_point        r_p0, r_p1, r_p2;
    logic signed [MW-1:0]    r_gt [0:5];
    logic signed [MW-1:0]    r_as [0:2];
    logic signed [MW-1:0]    r_c1;
    logic signed [aavr_pkg::EW-1:0] r_m [0:8];
    logic signed [aavr_pkg::QW-1:0] r_q [0:8];
    logic signed [31:0]      r_rot [0:2];
    logic                    r_sat;

    logic signed [MW-1:0]    w_c, w_sn;
    logic signed [31:0]      w_pv [0:2];
    logic signed [aavr_pkg::SW-1:0] w_sum [0:2];
    logic signed [31:0]      n_rot [0:2];
    logic                    n_sat;

    assign w_c  = i_trig.cneg ? -MW'(i_trig.x) : MW'(i_trig.x);
    assign w_sn = i_trig.sneg ? -MW'(i_trig.y) : MW'(i_trig.y);

    assign w_pv[0] = r_p2.x;
    assign w_pv[1] = r_p2.y;
    assign w_pv[2] = r_p2.z;

    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = aavr_pkg::SW'(r_q[3*r]) + aavr_pkg::SW'(r_q[3*r+1])
                     + aavr_pkg::SW'(r_q[3*r+2]);
            if (w_sum[r] > aavr_pkg::SW'(32'sh7FFFFFFF)) begin
                n_rot[r] = 32'sh7FFFFFFF;
                n_sat    = 1'b1;
            end else if (w_sum[r] < aavr_pkg::SW'(-33'sd2147483648)) begin
                n_rot[r] = 32'sh80000000;
                n_sat    = 1'b1;
            end else begin
                n_rot[r] = w_sum[r][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
        // Sign fix and one minus cosine.
        r_c0  <= w_c;
        r_sn0 <= w_sn;
        r_t0  <= aavr_pkg::ONE_Q30 - w_c;
        r_p0  <= i_trig.pt;
        // Scaled products.
        for (int k = 0; k < 6; k++) begin
            r_gt[k] <= MW'(aavr_pkg::mul_rnd30(40'(i_gram[k]), 40'(r_t0)));
        end
        for (int k = 0; k < 3; k++) begin
            r_as[k] <= MW'(aavr_pkg::mul_rnd30(40'(i_axis[k]), 40'(r_sn0)));
        end
        r_c1 <= r_c0;
        r_p1 <= r_p0;
        // Matrix entries, row major.
        r_m[0] <= aavr_pkg::EW'(r_gt[0]) + aavr_pkg::EW'(r_c1);
        r_m[1] <= aavr_pkg::EW'(r_gt[3]) - aavr_pkg::EW'(r_as[2]);
        r_m[2] <= aavr_pkg::EW'(r_gt[5]) + aavr_pkg::EW'(r_as[1]);
        r_m[3] <= aavr_pkg::EW'(r_gt[3]) + aavr_pkg::EW'(r_as[2]);
        r_m[4] <= aavr_pkg::EW'(r_gt[1]) + aavr_pkg::EW'(r_c1);
        r_m[5] <= aavr_pkg::EW'(r_gt[4]) - aavr_pkg::EW'(r_as[0]);
        r_m[6] <= aavr_pkg::EW'(r_gt[5]) - aavr_pkg::EW'(r_as[1]);
        r_m[7] <= aavr_pkg::EW'(r_gt[4]) + aavr_pkg::EW'(r_as[0]);
        r_m[8] <= aavr_pkg::EW'(r_gt[2]) + aavr_pkg::EW'(r_c1);
        r_p2 <= r_p1;
        // Entry times point component.
        for (int k = 0; k < 9; k++) begin
            r_q[k] <= aavr_pkg::QW'(aavr_pkg::mul_rnd30(40'(r_m[k]), 40'(w_pv[k%3])));
        end
        // Row sums and clipping.
        for (int r = 0; r < 3; r++) begin
            r_rot[r] <= n_rot[r];
        end
        r_sat <= n_sat;
    end

    assign o_valid     = r_v[4];
    assign o_rot       = r_rot;
    assign o_saturated = r_sat;

endmodule

### hdl/axis_angle_vector_rotation.sv
// Each start transfer passes through two angle stages, one stage per CORDIC
// iteration and five matrix stages before its result appears.
// Throughput: one transfer per cycle; busy stays low and nothing stalls.
// Reset clears all valid bits and sets the axis to (0, 0, 1.0).
// Depends on aavr_pkg, aavr_angle, aavr_cordic and aavr_matrix.
module axis_angle_vector_rotation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    input  logic signed [25:0]  i_angle_deg,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_valid,
    output logic signed [31:0]  o_rot_x,
    output logic signed [31:0]  o_rot_y,
    output logic signed [31:0]  o_rot_z,
    output logic                o_saturated
);

    logic signed [31:0]               r_axis [0:2];
    logic signed [aavr_pkg::GW-1:0]   r_gram [0:5];
    aavr_pkg::t_point                 w_pt;
    logic                             w_acc;
    logic                             w_av;
    aavr_pkg::t_angle                 w_ang;
    logic                             w_cv;
    aavr_pkg::t_trig                  w_trig;
    logic signed [31:0]               w_rot [0:2];

    assign o_busy = 1'b0;
    assign w_acc  = i_start & ~o_busy;
    assign w_pt.x = i_point_x;
    assign w_pt.y = i_point_y;
    assign w_pt.z = i_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis[0] <= aavr_pkg::AXIS_X_RST;
            r_axis[1] <= aavr_pkg::AXIS_Y_RST;
            r_axis[2] <= aavr_pkg::AXIS_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aavr_pkg::REG_AXIS_X: r_axis[0] <= i_cfg_data;
                aavr_pkg::REG_AXIS_Y: r_axis[1] <= i_cfg_data;
                aavr_pkg::REG_AXIS_Z: r_axis[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Axis outer products are registered and follow the axis registers in the next
    // cycle, long before an item started after a write reaches the matrix stages.
    always_ff @(posedge i_clk) begin
        r_gram[0] <= aavr_pkg::GW'(aavr_pkg::mul_rnd30(40'(r_axis[0]), 40'(r_axis[0])));
        r_gram[1] <= aavr_pkg::GW'(aavr_pkg::mul_rnd30(40'(r_axis[1]), 40'(r_axis[1])));
        r_gram[2] <= aavr_pkg::GW'(aavr_pkg::mul_rnd30(40'(r_axis[2]), 40'(r_axis[2])));
        r_gram[3] <= aavr_pkg::GW'(aavr_pkg::mul_rnd30(40'(r_axis[0]), 40'(r_axis[1])));
        r_gram[4] <= aavr_pkg::GW'(aavr_pkg::mul_rnd30(40'(r_axis[1]), 40'(r_axis[2])));
        r_gram[5] <= aavr_pkg::GW'(aavr_pkg::mul_rnd30(40'(r_axis[2]), 40'(r_axis[0])));
    end

    aavr_angle u_angle (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_acc),
        .i_angle_deg (i_angle_deg),
        .i_pt        (w_pt),
        .o_valid     (w_av),
        .o_ang       (w_ang)
    );

    aavr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_av),
        .i_ang   (w_ang),
        .o_valid (w_cv),
        .o_trig  (w_trig)
    );

    aavr_matrix u_matrix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_cv),
        .i_trig      (w_trig),
        .i_axis      (r_axis),
        .i_gram      (r_gram),
        .o_valid     (o_valid),
        .o_rot       (w_rot),
        .o_saturated (o_saturated)
    );

    assign o_rot_x = w_rot[0];
    assign o_rot_y = w_rot[1];
    assign o_rot_z = w_rot[2];

`ifndef SYNTHESIS
    // A strobe never appears in the cycle right after reset.
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // A clipped result has at least one component at a range limit.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_rot_x == 32'sh7FFFFFFF || o_rot_x == 32'sh80000000 ||
             o_rot_y == 32'sh7FFFFFFF || o_rot_y == 32'sh80000000 ||
             o_rot_z == 32'sh7FFFFFFF || o_rot_z == 32'sh80000000))
        else $error("saturation flag without a clipped component");
`endif

endmodule

### verif/axis_angle_vector_rotation_test.sv
// Self-checking testbench for axis_angle_vector_rotation: drives points and angles,
// predicts each rotated point in a scoreboard class, and checks every result.
// Depends on aavr_pkg and the block's RTL.
`timescale 1ns / 100ps

class rotation_scoreboard;
    typedef struct {
        logic signed [31:0] x, y, z;
        logic               sat;
    } t_rot;

    longint ax, ay, az;
    t_rot   pending[$];
    int     errors;
    int     checked;

    function new();
        ax = 0; ay = 0; az = 1073741824;
        errors = 0; checked = 0;
    endfunction

    function void set_axis(logic [1:0] idx, logic [31:0] v);
        longint s;
        s = longint'(signed'(v));
        if (idx == aavr_pkg::REG_AXIS_X) ax = s;
        else if (idx == aavr_pkg::REG_AXIS_Y) ay = s;
        else if (idx == aavr_pkg::REG_AXIS_Z) az = s;
    endfunction

    // round(a*b/2^s), ties away from zero, in a wide intermediate.
    function longint rmul(longint a, longint b, int s);
        logic signed [127:0] p;
        logic [127:0]        m;
        p = 128'(signed'(a)) * 128'(signed'(b));
        m = p[127] ? -p : p;
        m = (m + (128'd1 << (s - 1))) >> s;
        return p[127] ? -longint'(m[62:0]) : longint'(m[62:0]);
    endfunction

    function longint atan_entry(int i);
        longint tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
            32, 16, 8, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function void note_input(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [25:0] ang);
        longint a, half, quarter, x, y, z, c, sn, t, dx, dy, acc;
        longint xx, yy, zz, xy, yz, zx;
        longint p[3];
        longint m[3][3];
        bit cneg, sneg;
        t_rot r;
        longint res[3];
        half = 180 * 65536; quarter = 90 * 65536;
        a = longint'(signed'(ang));
        p[0] = longint'(signed'(px));
        p[1] = longint'(signed'(py));
        p[2] = longint'(signed'(pz));
        cneg = 0;
        r.sat = 0;
        while (a >= half) a -= 2 * half;
        while (a < -half) a += 2 * half;
        if (a > quarter) begin
            a = half - a; cneg = 1;
        end else if (a < -quarter) begin
            a = -half - a; cneg = 1;
        end
        sneg = a < 0;
        z = rmul(sneg ? -a : a, 74961321, 18);
        x = 652032874; y = 0;
        for (int i = 0; i < aavr_pkg::CORDIC_ITERATIONS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        c = cneg ? -x : x;
        sn = sneg ? -y : y;
        t = (64'sd1 << 30) - c;
        xx = rmul(ax, ax, 30); yy = rmul(ay, ay, 30); zz = rmul(az, az, 30);
        xy = rmul(ax, ay, 30); yz = rmul(ay, az, 30); zx = rmul(az, ax, 30);
        m[0][0] = rmul(xx, t, 30) + c;
        m[0][1] = rmul(xy, t, 30) - rmul(az, sn, 30);
        m[0][2] = rmul(zx, t, 30) + rmul(ay, sn, 30);
        m[1][0] = rmul(xy, t, 30) + rmul(az, sn, 30);
        m[1][1] = rmul(yy, t, 30) + c;
        m[1][2] = rmul(yz, t, 30) - rmul(ax, sn, 30);
        m[2][0] = rmul(zx, t, 30) - rmul(ay, sn, 30);
        m[2][1] = rmul(yz, t, 30) + rmul(ax, sn, 30);
        m[2][2] = rmul(zz, t, 30) + c;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += rmul(m[i][j], p[j], 30);
            if (acc > 64'sd2147483647) begin
                acc = 64'sd2147483647; r.sat = 1;
            end else if (acc < -64'sd2147483648) begin
                acc = -64'sd2147483648; r.sat = 1;
            end
            res[i] = acc;
        end
        r.x = res[0][31:0]; r.y = res[1][31:0]; r.z = res[2][31:0];
        pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                               logic sat);
        t_rot e;
        if (pending.size() == 0) begin
            $error("result with no transfer outstanding");
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (rx !== e.x) begin
            $error("rot_x expected %0d actual %0d", e.x, signed'(rx)); errors++;
        end
        if (ry !== e.y) begin
            $error("rot_y expected %0d actual %0d", e.y, signed'(ry)); errors++;
        end
        if (rz !== e.z) begin
            $error("rot_z expected %0d actual %0d", e.z, signed'(rz)); errors++;
        end
        if (sat !== e.sat) begin
            $error("saturated expected %0d actual %0d", e.sat, sat); errors++;
        end
    endfunction
endclass

module axis_angle_vector_rotation_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [25:0] ANG_MAX = 26'sd33554431;
    localparam logic signed [25:0] ANG_MIN = 26'sh2000000;

    logic i_clk = 0, i_rst_n = 0, i_start = 0, i_cfg_we = 0;
    logic signed [31:0] i_point_x = 0, i_point_y = 0, i_point_z = 0;
    logic signed [25:0] i_angle_deg = 0;
    logic [1:0]  i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_busy, o_valid, o_saturated;
    logic signed [31:0] o_rot_x, o_rot_y, o_rot_z;

    rotation_scoreboard rotations = new();
    int cycles = 0;
    int sent = 0;

    axis_angle_vector_rotation dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("axis_angle_vector_rotation verification failed");
            $finish;
        end
        if (i_rst_n && o_valid) rotations.check_result(o_rot_x, o_rot_y, o_rot_z, o_saturated);
    end

    task automatic write_axis(logic [1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        rotations.set_axis(idx, v);
    endtask

    task automatic set_axis(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        write_axis(aavr_pkg::REG_AXIS_X, x);
        write_axis(aavr_pkg::REG_AXIS_Y, y);
        write_axis(aavr_pkg::REG_AXIS_Z, z);
    endtask

    // Holds start high until the block takes the transfer; unless the next item
    // follows immediately, it then drops start and idles before returning.
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [25:0] ang, bit keep);
        i_start <= 1;
        i_point_x <= px; i_point_y <= py; i_point_z <= pz; i_angle_deg <= ang;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        rotations.note_input(px, py, pz, ang);
        sent++;
        if (!keep) begin
            i_start <= 0;
            @(posedge i_clk);
        end
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (g) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [25:0] rand_angle();
        case ($urandom_range(0, 7))
            0: return 26'($urandom);
            1: return 26'($urandom_range(0, 8) * 90 * 65536 - 360 * 65536);
            default: return 26'($signed($urandom_range(0, 47185920)) - 23592960);
        endcase
    endfunction

    task automatic drain();
        while (rotations.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge i_clk);
        repeat (aavr_pkg::PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        bit keep;
        for (int k = 0; k < n; k++) begin
            keep = ($urandom_range(0, 1) == 1) && (k != n - 1);
            send_point(rand_coord(), rand_coord(), rand_coord(), rand_angle(), keep);
            if (!keep) random_gap();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        // Reset axis, angle extremes and folding boundaries.
        send_point(32'h00010000, 32'h00020000, 32'h00030000, 26'(90 * 65536), 0);
        send_point(32'h00010000, 32'h0, 32'h0, 26'(180 * 65536), 0);
        send_point(32'h00010000, 32'h0, 32'h0, 26'(-180 * 65536), 1);
        send_point(32'h00010000, 32'h00010000, 32'h0, 26'(-90 * 65536), 1);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, ANG_MAX, 1);
        send_point(32'h80000000, 32'h7fffffff, 32'h80000000, ANG_MIN, 0);
        send_point(32'h00012345, 32'hfffe0000, 32'h0, 26'(360 * 65536), 0);
        send_point(32'h00012345, 32'hfffe0000, 32'h0, 26'(-360 * 65536), 0);
        send_point(32'h0, 32'h0, 32'h0, 26'd0, 0);
        drain();
        // Extreme, non-unit axes drive the result into clipping.
        set_axis(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 26'(45 * 65536), 0);
        send_point(32'h80000000, 32'h7fffffff, 32'h12345678, 26'(-135 * 65536), 0);
        send_point(32'h40000000, 32'hc0000000, 32'h1, 26'(1), 0);
        drain();
        write_axis(2'd3, 32'hffffffff);
        send_point(32'h00010000, 32'h00010000, 32'h00010000, 26'(30 * 65536), 0);
        drain();
        random_phase(200);
        drain();
        set_axis(32'h80000000, 32'h0, 32'h0);
        random_phase(150);
        drain();
        set_axis(32'h24f34e8b, 32'h24f34e8b, 32'h24f34e8b);
        random_phase(250);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            set_axis($urandom, $urandom, $urandom);
            random_phase(110);
            drain();
        end
        if (rotations.pending.size() != 0) begin
            $error("%0d results never arrived", rotations.pending.size());
            rotations.errors++;
        end
        $display("Sent %0d points over seven axis settings, %0d results checked.",
                 sent, rotations.checked);
        if (rotations.errors == 0 && cycles < CYCLE_LIMIT)
            $display("axis_angle_vector_rotation verification clean");
        else
            $display("axis_angle_vector_rotation verification failed");
        $finish;
    end
endmodule
